>>> rtl/rasr_pkg.sv
// Package for the rational add/subtract/reduce block: word types, operation codes
// and width constants. It has no dependencies.
package rasr_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        OP_REDUCE = 2'd0,
        OP_ADD    = 2'd1,
        OP_SUB    = 2'd2,
        OP_INC    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               zero_den_error;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic form;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic special;
        logic gcd_done;
        logic div_done;
    } stat_t;

endpackage

>>> rtl/rasr_ctrl.sv
// Controller state machine of the rational add/subtract/reduce block.
// Depends on rasr_pkg for the command and status structs.
module rasr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    output rasr_pkg::cmd_t  cmd,
    input  rasr_pkg::stat_t stat
);
    import rasr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL1 = 7'b0000010,
        S_MUL2 = 7'b0000100,
        S_FORM = 7'b0001000,
        S_GCD  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2 = 1'b1;
                state_next = S_FORM;
            end
            S_FORM:
            begin
                cmd.form = 1'b1;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (stat.special)
                begin
                    state_next = S_DONE;
                end
                else if (stat.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

>>> rtl/rasr_dp.sv
// Datapath of the rational add/subtract/reduce block: raw fraction forming,
// binary GCD and two restoring dividers that run side by side. Depends on rasr_pkg.
module rasr_dp #(
    parameter int DATA_WIDTH = rasr_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rasr_pkg::cmd_t        cmd,
    output rasr_pkg::stat_t       stat,
    input  logic [1:0]            op,
    input  logic [DATA_WIDTH-1:0] a_num,
    input  logic [DATA_WIDTH-1:0] a_den,
    input  logic [DATA_WIDTH-1:0] b_num,
    input  logic [DATA_WIDTH-1:0] b_den,
    output logic [DATA_WIDTH-1:0] out_num,
    output logic [DATA_WIDTH-2:0] out_den,
    output logic                  out_err
);
    import rasr_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [1:0]   op_reg;
    logic [W-1:0] p0_reg, p1_reg, p2_reg;
    logic [W-1:0] nm_reg, dm_reg;
    logic         neg_reg, special_reg, err_reg;
    logic [W-1:0] gx_reg, gy_reg;
    logic [CW-1:0] sh_reg;
    logic [W-1:0] g_reg;
    logic [W-1:0] qn_reg, qd_reg, rn_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0] raw_n, raw_d;
    logic [W-1:0] mag_n, mag_d;
    logic [W-1:0] gdiff;
    logic [W:0]   trn, trd;
    logic [W-1:0] fin_n;
    logic [W-2:0] fin_d;

    // Raw fraction from the operand registers and products.
    always_comb
    begin
        case (op_t'(op_reg))
            OP_ADD:
            begin
                raw_n = p0_reg + p1_reg;
                raw_d = p2_reg;
            end
            OP_SUB:
            begin
                raw_n = p0_reg - p1_reg;
                raw_d = p2_reg;
            end
            OP_INC:
            begin
                raw_n = an_reg + ad_reg;
                raw_d = ad_reg;
            end
            default:
            begin
                raw_n = an_reg;
                raw_d = ad_reg;
            end
        endcase
        mag_n = raw_n[W-1] ? (~raw_n + 1'b1) : raw_n;
        mag_d = raw_d[W-1] ? (~raw_d + 1'b1) : raw_d;
        gdiff = (gx_reg > gy_reg) ? (gx_reg - gy_reg) : (gy_reg - gx_reg);
        trn = {rn_reg[W-2:0], qn_reg[W-1]} - {1'b0, g_reg};
        trd = {rd_reg[W-2:0], qd_reg[W-1]} - {1'b0, g_reg};
    end

    // Operand capture, products, GCD and division.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            an_reg <= a_num;
            ad_reg <= a_den;
            bn_reg <= b_num;
            bd_reg <= b_den;
        end
        if (cmd.mul1)
        begin
            p0_reg <= an_reg * bd_reg;
            p1_reg <= ad_reg * bn_reg;
        end
        if (cmd.mul2)
            p2_reg <= ad_reg * bd_reg;
        if (cmd.form)
        begin
            nm_reg  <= mag_n;
            dm_reg  <= mag_d;
            gx_reg  <= mag_n;
            gy_reg  <= mag_d;
            sh_reg  <= '0;
            neg_reg <= raw_n[W-1] ^ raw_d[W-1];
            err_reg <= (raw_d == '0);
        end
        // Binary GCD: strip common twos, then strip odd factors of two and subtract.
        if (cmd.gcd_step)
        begin
            if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                sh_reg <= sh_reg + 1'b1;
            end
            else if (!gx_reg[0])
                gx_reg <= gx_reg >> 1;
            else if (!gy_reg[0])
                gy_reg <= gy_reg >> 1;
            else if (gx_reg > gy_reg)
                gx_reg <= gdiff;
            else
                gy_reg <= gdiff;
        end
        if (cmd.div_init)
        begin
            g_reg   <= gx_reg << sh_reg;
            qn_reg  <= nm_reg;
            qd_reg  <= dm_reg;
            rn_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        // One quotient bit of both divisions per step.
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (!trn[W])
            begin
                rn_reg <= trn[W-1:0];
                qn_reg <= {qn_reg[W-2:0], 1'b1};
            end
            else
            begin
                rn_reg <= {rn_reg[W-2:0], qn_reg[W-1]};
                qn_reg <= {qn_reg[W-2:0], 1'b0};
            end
            if (!trd[W])
            begin
                rd_reg <= trd[W-1:0];
                qd_reg <= {qd_reg[W-2:0], 1'b1};
            end
            else
            begin
                rd_reg <= {rd_reg[W-2:0], qd_reg[W-1]};
                qd_reg <= {qd_reg[W-2:0], 1'b0};
            end
        end
    end

    // Zero numerator or denominator skips the reduction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            special_reg <= 1'b0;
        else if (cmd.form)
            special_reg <= (raw_d == '0) || (raw_n == '0);
    end

    // Result: sign to the numerator, saturate the denominator.
    always_comb
    begin
        fin_n = neg_reg ? (~qn_reg + 1'b1) : qn_reg;
        fin_d = qd_reg[W-1] ? {(W-1){1'b1}} : qd_reg[W-2:0];
        if (special_reg)
        begin
            out_num = '0;
            out_den = {{(W-2){1'b0}}, 1'b1};
        end
        else
        begin
            out_num = fin_n;
            out_den = fin_d;
        end
        out_err = special_reg & err_reg;
    end

    assign stat.special  = special_reg;
    assign stat.gcd_done = (gx_reg == gy_reg);
    assign stat.div_done = (cnt_reg == CW'(W));

endmodule

>>> rtl/rational_add_sub_reduce.sv
// Top level of the rational add/subtract/reduce block.
// Depends on rasr_pkg, rasr_ctrl and rasr_dp.
//
// A request word is taken at a clock edge where start is high and busy is low.
// busy stays high until the result word has been shown; one request is in work
// at a time. The result word is on result for exactly one cycle, marked by
// done; the receiver cannot hold it off and must take it then.
// Order of work after the accepting edge: the states MUL1 and MUL2 multiply, FORM
// forms the raw fraction, then the binary GCD loop runs (one shift or subtract per
// cycle, until both values match), then the two restoring dividers run side by
// side, then the DONE state shows the result word. A zero numerator or denominator
// skips the GCD and division. The length of the GCD loop depends on the operands.
// The next request can be taken in the cycle after the result word.
// Reset returns the controller to idle; no result is pending after it.
module rational_add_sub_reduce #(
    parameter int DATA_WIDTH = rasr_pkg::DATA_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rasr_pkg::req_t req,
    output logic           done,
    output rasr_pkg::res_t result
);
    import rasr_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic [DATA_WIDTH-1:0] o_num;
    logic [DATA_WIDTH-2:0] o_den;
    logic                  o_err;

    rasr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    rasr_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .op      (req.req_type),
        .a_num   (DATA_WIDTH'(req.a_num)),
        .a_den   (DATA_WIDTH'(req.a_den)),
        .b_num   (DATA_WIDTH'(req.b_num)),
        .b_den   (DATA_WIDTH'(req.b_den)),
        .out_num (o_num),
        .out_den (o_den),
        .out_err (o_err)
    );

    assign result.res_num        = 32'(o_num);
    assign result.res_den        = 31'(o_den);
    assign result.zero_den_error = o_err;

    // A result word only appears while the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");
    // Result is seen for one cycle only.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held");
    // An error result is always 0/1.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.zero_den_error) |-> (result.res_num == 0 && result.res_den == 1))
        else $error("bad error result");

endmodule

>>> tb/rasr_checker.sv
// Checker for the rational add/subtract/reduce block: watches request and result
// words, predicts each result and compares. Depends on rasr_pkg.
`timescale 1ns / 100ps

module rasr_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  rasr_pkg::req_t req,
    input  logic           done,
    input  rasr_pkg::res_t result,
    output int             fail_count,
    output int             pending_count
);
    import rasr_pkg::*;

    res_t expected_fractions[$];

    // Magnitude of a 32-bit two's complement value, held in 33 bits.
    function automatic logic [32:0] mag32(input logic [31:0] v);
        if (v[31])
            return {1'b0, (~v) + 32'd1};
        return {1'b0, v};
    endfunction

    // Works out the reduced fraction for one request word.
    function automatic res_t reduce_fraction(input req_t r);
        logic [31:0] n, d, g_a, g_b, t;
        logic [32:0] nm, dm;
        logic        neg;
        res_t        o;
        case (op_t'(r.req_type))
            OP_ADD:
            begin
                n = r.a_num * r.b_den + r.a_den * r.b_num;
                d = r.a_den * r.b_den;
            end
            OP_SUB:
            begin
                n = r.a_num * r.b_den - r.a_den * r.b_num;
                d = r.a_den * r.b_den;
            end
            OP_INC:
            begin
                n = r.a_num + r.a_den;
                d = r.a_den;
            end
            default:
            begin
                n = r.a_num;
                d = r.a_den;
            end
        endcase
        o = '0;
        if (d == 0)
        begin
            o.res_den = 31'd1;
            o.zero_den_error = 1'b1;
            return o;
        end
        if (n == 0)
        begin
            o.res_den = 31'd1;
            return o;
        end
        neg = n[31] ^ d[31];
        nm = mag32(n);
        dm = mag32(d);
        // Euclid over the magnitudes; 2^31 fits in 32 unsigned bits.
        g_a = nm[31:0] | {nm[32], 31'd0};
        g_b = dm[31:0];
        while (g_b != 0)
        begin
            t = g_a % g_b;
            g_a = g_b;
            g_b = t;
        end
        nm = nm / g_a;
        dm = dm / g_a;
        o.res_num = neg ? (~nm[31:0]) + 32'd1 : nm[31:0];
        o.res_den = (dm > 33'h7FFF_FFFF) ? 31'h7FFF_FFFF : dm[30:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
    end

    assign pending_count = expected_fractions.size();

    // Predict on accepted request words; compare each result word.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_fractions.size() == 0)
                    report_mismatch("unexpected result word", result.res_num, 32'd0);
                else
                begin
                    want = expected_fractions.pop_front();
                    if (result.res_num !== want.res_num)
                        report_mismatch("res_num", result.res_num, want.res_num);
                    if (result.res_den !== want.res_den)
                        report_mismatch("res_den", {1'b0, result.res_den},
                                        {1'b0, want.res_den});
                    if (result.zero_den_error !== want.zero_den_error)
                        report_mismatch("zero_den_error", {31'd0, result.zero_den_error},
                                        {31'd0, want.zero_den_error});
                end
            end
            if (start && !busy)
                expected_fractions.push_back(reduce_fraction(req));
        end
    end
endmodule

>>> tb/testbench.sv
// Top of the testbench for rational_add_sub_reduce: clock, reset, stimulus and
// verdict. Depends on rasr_pkg, the block and rasr_checker.
`timescale 1ns / 100ps

module testbench;
    import rasr_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;

    logic clk, rst_n, start, busy, done;
    req_t req;
    res_t result;
    int   fail_count, pending_count;
    int   cycles;
    int   gap_pct;

    rational_add_sub_reduce uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .result(result)
    );

    rasr_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .result(result), .fail_count(fail_count),
        .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle limit in case the block hangs.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Picks an operand value, weighted towards awkward edges.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
            4: return $urandom_range(0, 2000) - 1000;
            5: return ($urandom_range(1, 300)) << $urandom_range(0, 24);
            6: return $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Presents one request word at a falling edge and holds it until accepted.
    // busy only changes at rising edges, so it is steady when looked at here.
    task automatic send_request(input op_t op, input logic [31:0] an,
                                input logic [31:0] ad, input logic [31:0] bn,
                                input logic [31:0] bd);
        while ($urandom_range(0, 99) < gap_pct)
            @(negedge clk);
        req = '{req_type: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        start = 1'b1;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_request(op_t'($urandom_range(0, 3)), pick_value(), pick_value(),
                         pick_value(), pick_value());
    endtask

    initial
    begin
        start = 1'b0;
        req = '0;
        rst_n = 1'b0;
        gap_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words: each operation, zero parts, overflow and saturation.
        send_request(OP_REDUCE, 32'd6, 32'd4, 32'd0, 32'd0);
        send_request(OP_REDUCE, 32'd6, -32'd4, 32'd0, 32'd0);
        send_request(OP_REDUCE, 32'd0, 32'd0, 32'd0, 32'd0);
        send_request(OP_REDUCE, 32'd0, 32'd7, 32'd0, 32'd0);
        send_request(OP_REDUCE, 32'd5, 32'd0, 32'd0, 32'd0);
        send_request(OP_REDUCE, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_request(OP_REDUCE, 32'd1, 32'h8000_0000, 32'd0, 32'd0);
        send_request(OP_REDUCE, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        send_request(OP_REDUCE, 32'h7FFF_FFFF, 32'h8000_0001, 32'd0, 32'd0);
        send_request(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_request(OP_ADD, 32'd1, 32'h0001_0000, 32'd1, 32'h0001_0000);
        send_request(OP_ADD, 32'd1, -32'd2, 32'd1, 32'd2);
        send_request(OP_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1);
        send_request(OP_SUB, 32'd3, 32'd4, 32'd1, 32'd4);
        send_request(OP_SUB, 32'd1, 32'd3, 32'd1, 32'd3);
        send_request(OP_SUB, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd5);
        send_request(OP_INC, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_INC, -32'd3, 32'd3, 32'd0, 32'd0);
        send_request(OP_INC, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0);
        send_request(OP_INC, 32'd4, 32'd0, 32'd9, 32'd9);

        // Random words in three idling phases, the last without gaps.
        gap_pct = 11;
        send_random(630);
        gap_pct = 46;
        send_random(630);
        gap_pct = 0;
        send_random(620);

        while (pending_count != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> sim.f
rtl/rasr_pkg.sv
rtl/rasr_ctrl.sv
rtl/rasr_dp.sv
rtl/rational_add_sub_reduce.sv
tb/rasr_checker.sv
tb/testbench.sv
